/* rtl/core/mrr_pkg.sv */
// shared constants, types and command/status structs for the rectangle raster engine
`timescale 1ns / 1ps
`default_nettype none
package mrr_pkg;

    localparam int SCREEN_WIDTH  = 250;
    localparam int SCREEN_HEIGHT = 122;
    localparam int FRAME_BYTES   = 4096;

    localparam int MODE_W  = 2;
    localparam int COORD_W = 12;
    localparam int BADDR_W = 12;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = $clog2(FRAME_BYTES);
    localparam int X_W     = $clog2(SCREEN_WIDTH);
    localparam int Y_W     = $clog2(SCREEN_HEIGHT);
    localparam int LIN_W   = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
    localparam int BIT_W   = 3;

    localparam logic [BYTE_W-1:0] WHITE_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] MSB_MASK   = 8'h80;

    typedef enum logic [MODE_W-1:0] {
        MODE_PLOT  = 2'd0,
        MODE_RECT  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_RECT_CHK,
        S_PIX_ADDR,
        S_PIX_READ,
        S_PIX_WRITE,
        S_CLR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic pix_addr;
        logic pix_read;
        logic pix_write;
        logic clr_wr;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic rect_end;
        logic paint;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

/* rtl/core/monochrome_rectangle_raster_engine_top.sv */
// top level of the one-bit framebuffer rectangle raster engine
`timescale 1ns / 1ps
`default_nettype none
// throughput: one command at a time; read goes through load and finish, plot through pixel
//   address, read, write and finish, clear writes all FRAME_BYTES bytes (one byte write per cycle)
// rectangle: one check per visited position plus a read-modify-write of one framebuffer byte
//   per painted pixel; outlines visit only edge rows fully
// reset: synchronous active low; afterwards a clearing pass writes 0xFF to all FRAME_BYTES
//   bytes, one per cycle, with o_in_stall high until it ends
module monochrome_rectangle_raster_engine_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // command channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [mrr_pkg::MODE_W-1:0]          i_mode,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_xa,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_ya,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_xb,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_yb,
    input  wire logic                                i_fill,
    input  wire logic                                i_ink,
    input  wire logic [mrr_pkg::BADDR_W-1:0]         i_byte_addr,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [mrr_pkg::BYTE_W-1:0]               o_read_byte,
    output logic                                     o_done_res
);
    import mrr_pkg::*;

    // command and status between the sequencer and the datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: decodes the mode on a transfer, walks rectangles, sweeps clears
    mrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: coordinates, framebuffer memory and the output register
    // a finished result waits in the output register while the next command is taken
    mrr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_mode      (i_mode),
        .i_xa        (i_xa),
        .i_ya        (i_ya),
        .i_xb        (i_xb),
        .i_yb        (i_yb),
        .i_fill      (i_fill),
        .i_ink       (i_ink),
        .i_byte_addr (i_byte_addr),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_read_byte (o_read_byte)
    );

    // every result marks a finished command
    assign o_done_res = 1'b1;

endmodule
`default_nettype wire

/* rtl/core/mrr_ctrl.sv */
// controller state machine: command decode, rectangle walk and clear sequencing
`timescale 1ns / 1ps
`default_nettype none
module mrr_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [mrr_pkg::MODE_W-1:0]  i_mode,
    input  wire mrr_pkg::t_dp_sts            i_sts,
    output mrr_pkg::t_dp_cmd                 o_cmd,
    output logic                             o_in_stall
);
    import mrr_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_CLR;
            r_mode  <= MODE_PLOT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_INIT_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = t_mode'(i_mode);
                    case (t_mode'(i_mode))
                        MODE_PLOT:  n_state = S_PIX_ADDR;
                        MODE_RECT:  n_state = S_RECT_CHK;
                        MODE_CLEAR: n_state = S_CLR;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end
            S_RECT_CHK: begin
                if (i_sts.rect_end) begin
                    n_state = S_FINISH;
                end else if (i_sts.paint) begin
                    n_state = S_PIX_ADDR;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_PIX_ADDR: begin
                o_cmd.pix_addr = 1'b1;
                n_state        = S_PIX_READ;
            end
            S_PIX_READ: begin
                o_cmd.pix_read = 1'b1;
                n_state        = S_PIX_WRITE;
            end
            S_PIX_WRITE: begin
                o_cmd.pix_write = 1'b1;
                if (r_mode == MODE_RECT) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RECT_CHK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/mrr_datapath.sv */
// datapath: corner registers, pixel walker, framebuffer memory and output register
`timescale 1ns / 1ps
`default_nettype none
module mrr_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mrr_pkg::t_dp_cmd                    i_cmd,
    output mrr_pkg::t_dp_sts                         o_sts,
    input  wire logic [mrr_pkg::MODE_W-1:0]          i_mode,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_xa,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_ya,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_xb,
    input  wire logic signed [mrr_pkg::COORD_W-1:0]  i_yb,
    input  wire logic                                i_fill,
    input  wire logic                                i_ink,
    input  wire logic [mrr_pkg::BADDR_W-1:0]         i_byte_addr,
    input  wire logic                                i_out_stall,
    output logic                                     o_out_valid,
    output logic [mrr_pkg::BYTE_W-1:0]               o_read_byte
);
    import mrr_pkg::*;

    localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic signed [COORD_W-1:0] C_ZERO = '0;
    localparam logic signed [COORD_W-1:0] C_ONE  = COORD_W'(1);
    localparam logic [LIN_W-1:0] LIN_STRIDE = LIN_W'(SCREEN_WIDTH);

    logic [BYTE_W-1:0] mem [FRAME_BYTES];

    // rectangle geometry, sorted corners and visible bounds
    logic signed [COORD_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic signed [COORD_W-1:0] r_cx0, r_cx1, r_cy1;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic                      r_fill, r_black;
    logic                      r_is_read, r_baddr_ok;
    logic [LIN_W-1:0]          r_lin;
    logic [BIT_W-1:0]          r_bit;
    logic                      r_pix_ok;
    logic [BYTE_W-1:0]         r_rdata;
    logic [ADDR_W-1:0]         r_addr;
    logic                      r_out_valid;
    logic [BYTE_W-1:0]         r_read_byte;

    logic signed [COORD_W-1:0] w_sx0, w_sx1, w_sy0, w_sy1;
    logic signed [COORD_W-1:0] w_cx0, w_cx1, w_cy0, w_cy1;
    logic signed [COORD_W-1:0] w_nx;
    logic                      w_edge_row, w_on;
    logic [LIN_W-1:0]          w_lin;
    logic [ADDR_W-1:0]         w_pix_idx, w_rd_idx, w_wr_idx;
    logic [BYTE_W-1:0]         w_mask, w_wr_data;
    logic                      w_wr_en, w_rd_en, w_is_plot;

    always_comb begin
        w_sx0 = (i_xa > i_xb) ? i_xb : i_xa;
        w_sx1 = (i_xa > i_xb) ? i_xa : i_xb;
        w_sy0 = (i_ya > i_yb) ? i_yb : i_ya;
        w_sy1 = (i_ya > i_yb) ? i_ya : i_yb;
        w_cx0 = (w_sx0 < C_ZERO) ? C_ZERO : w_sx0;
        w_cx1 = (w_sx1 > X_MAX) ? X_MAX : w_sx1;
        w_cy0 = (w_sy0 < C_ZERO) ? C_ZERO : w_sy0;
        w_cy1 = (w_sy1 > Y_MAX) ? Y_MAX : w_sy1;
        w_is_plot = (t_mode'(i_mode) == MODE_PLOT);
    end

    // outline interior rows jump from the left edge straight to the right edge
    always_comb begin
        w_edge_row = (r_y == r_y0) || (r_y == r_y1);
        w_nx       = (r_fill || w_edge_row || (r_x >= r_x1)) ? (r_x + C_ONE) : r_x1;
        w_on       = (r_x >= C_ZERO) && (r_x <= X_MAX) && (r_y >= C_ZERO) && (r_y <= Y_MAX);
        w_lin      = LIN_W'(r_y[Y_W-1:0]) * LIN_STRIDE + LIN_W'(r_x[X_W-1:0]);
        w_pix_idx  = ADDR_W'(r_lin >> BIT_W);
        w_mask     = MSB_MASK >> r_bit;
        w_wr_data  = i_cmd.clr_wr ? WHITE_BYTE
                   : (r_black ? (r_rdata & ~w_mask) : (r_rdata | w_mask));
        w_wr_idx   = i_cmd.clr_wr ? r_addr : w_pix_idx;
        w_wr_en    = i_cmd.clr_wr || (i_cmd.pix_write && r_pix_ok);
        w_rd_idx   = i_cmd.load ? ADDR_W'(i_byte_addr) : w_pix_idx;
        w_rd_en    = i_cmd.load || i_cmd.pix_read;
    end

    always_comb begin
        o_sts.rect_end = (r_y > r_cy1) || (r_cx0 > r_cx1);
        o_sts.paint    = r_fill || w_edge_row || (r_x == r_x0) || (r_x == r_x1);
        o_sts.clr_last = (r_addr == ADDR_W'(FRAME_BYTES - 1));
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_idx] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0       <= w_sx0;
            r_x1       <= w_sx1;
            r_y0       <= w_sy0;
            r_y1       <= w_sy1;
            r_cx0      <= w_cx0;
            r_cx1      <= w_cx1;
            r_cy1      <= w_cy1;
            r_x        <= w_is_plot ? i_xa : w_cx0;
            r_y        <= w_is_plot ? i_ya : w_cy0;
            r_fill     <= i_fill;
            r_black    <= w_is_plot ? i_ink : 1'b1;
            r_is_read  <= (t_mode'(i_mode) == MODE_READ);
            r_baddr_ok <= (int'(i_byte_addr) < FRAME_BYTES);
        end else if (i_cmd.step) begin
            if (w_nx > r_cx1) begin
                r_x <= r_cx0;
                r_y <= r_y + C_ONE;
            end else begin
                r_x <= w_nx;
            end
        end
        if (i_cmd.pix_addr) begin
            r_lin    <= w_lin;
            r_bit    <= r_x[BIT_W-1:0];
            r_pix_ok <= w_on && (int'(w_lin >> BIT_W) < FRAME_BYTES);
        end
        if (i_cmd.emit) begin
            r_read_byte <= (r_is_read && r_baddr_ok) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_read_byte;

endmodule
`default_nettype wire

/* rtl/core/mrr_checker.sv */
// port-level checks for the raster engine top and the bind that attaches them
`timescale 1ns / 1ps
`default_nettype none
module mrr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [mrr_pkg::BYTE_W-1:0] o_read_byte,
    input wire logic                       o_done_res
);
    import mrr_pkg::*;

    // reset starts the clearing pass: nothing accepted, no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("block not quiet after reset");

    // every shown result carries the done flag
    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_done_res)
        else $error("result without done flag");

    // once a command is taken the input stalls while the engine works on it
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command taken while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_read_byte))
        else $error("result changed while stalled");

endmodule

bind monochrome_rectangle_raster_engine_top mrr_checker u_mrr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_byte (o_read_byte),
    .o_done_res  (o_done_res)
);
`default_nettype wire
